### src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int CMD_W     = 2;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 11;
  localparam int CAP_RESET = 1024;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  // Per-transaction status carried alongside the store read
  typedef struct packed {
    logic  ok;
    logic  empty;
    logic  full;
    logic  fwd_front;
    logic  fwd_back;
    data_t wdata;
  } meta_t;

endpackage

`default_nettype wire

### src/cdq_cmd_if.sv
// ----------------------------------------------------------------------------
// cdq_cmd_if
// Command channel: one deque operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_cmd_if
  import cdq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  data_t            push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

`default_nettype wire

### src/cdq_res_if.sv
// ----------------------------------------------------------------------------
// cdq_res_if
// Result channel: status and end entries after each command.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_res_if
  import cdq_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  ok;
  data_t front_value;
  data_t back_value;
  logic  is_empty;
  logic  is_full;

  modport source (output valid, output ok, output front_value, output back_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input back_value,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

### src/cdq_cfg_if.sv
// ----------------------------------------------------------------------------
// cdq_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_cfg_if
  import cdq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### src/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Ring store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram
  import cdq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire data_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr_front,
  input  wire logic [AW-1:0] rd_addr_back,
  output data_t              rd_front,
  output data_t              rd_back
);

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-before-write; same-address hits are forwarded downstream
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_front <= mem[rd_addr_front];
      rd_back  <= mem[rd_addr_back];
    end
  end

endmodule

`default_nettype wire

### src/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Pointer, count and capacity control; issues store writes and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             acc,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire data_t            push_value,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output data_t                 wr_data,
  output logic [AW-1:0]         rd_addr_front,
  output logic [AW-1:0]         rd_addr_back,
  output meta_t                 meta
);

  localparam int WW      = (CW > CAP_W) ? CW : CAP_W;
  localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cap;
  logic [WW-1:0] raw_cap;
  logic [WW-1:0] cap_clamped;
  logic          ok;
  cmd_t          op;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i,
                                            input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = CW'(i) + CW'(1);
    return (s >= c) ? '0 : AW'(s);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i,
                                              input logic [CW-1:0] c);
    return (i == '0) ? AW'(c - CW'(1)) : i - AW'(1);
  endfunction

  always_comb begin
    raw_cap = WW'(cfg_data);
    if (raw_cap == '0) begin
      cap_clamped = WW'(1);
    end else if (raw_cap > WW'(DEPTH)) begin
      cap_clamped = WW'(DEPTH);
    end else begin
      cap_clamped = raw_cap;
    end
  end

  always_comb begin
    op         = cmd_t'(cmd);
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ok         = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = tail;
    unique case (op)
      CMD_PUSH_FRONT: begin
        if (count < cap) begin
          head_next  = step_down(head, cap);
          wr_en      = acc;
          wr_addr    = head_next;
          count_next = count + CW'(1);
          ok         = 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (count < cap) begin
          wr_en      = acc;
          wr_addr    = tail;
          tail_next  = step_up(tail, cap);
          count_next = count + CW'(1);
          ok         = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (count != '0) begin
          head_next  = step_up(head, cap);
          count_next = count - CW'(1);
          ok         = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (count != '0) begin
          tail_next  = step_down(tail, cap);
          count_next = count - CW'(1);
          ok         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wr_data       = push_value;
  assign rd_addr_front = head_next;
  assign rd_addr_back  = step_down(tail_next, cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= CW'(CAP_RST);
    end else if (cfg_we) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= CW'(cap_clamped);
    end else if (acc) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Status held with the read data until the result moves on
  always_ff @(posedge clk) begin
    if (acc) begin
      meta.ok        <= ok;
      meta.empty     <= (count_next == '0);
      meta.full      <= (count_next == cap);
      meta.fwd_front <= wr_en && (wr_addr == rd_addr_front);
      meta.fwd_back  <= wr_en && (wr_addr == rd_addr_back);
      meta.wdata     <= push_value;
    end
  end

endmodule

`default_nettype wire

### src/cdq_out.sv
// ----------------------------------------------------------------------------
// cdq_out
// Result assembly and output register with a pending stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_out
  import cdq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  acc,
  input  wire meta_t meta,
  input  wire data_t rd_front,
  input  wire data_t rd_back,
  output logic       in_ready,
  cdq_res_if.source  rsp
);

  logic pend_vld;
  logic move;

  assign move     = pend_vld && (!rsp.valid || rsp.ready);
  assign in_ready = !pend_vld || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (acc) begin
        pend_vld <= 1'b1;
      end else if (move) begin
        pend_vld <= 1'b0;
      end
      if (move) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      rsp.ok       <= meta.ok;
      rsp.is_empty <= meta.empty;
      rsp.is_full  <= meta.full;
      if (meta.empty) begin
        rsp.front_value <= '1;
        rsp.back_value  <= '1;
      end else begin
        rsp.front_value <= meta.fwd_front ? meta.wdata : rd_front;
        rsp.back_value  <= meta.fwd_back  ? meta.wdata : rd_back;
      end
    end
  end

endmodule

`default_nettype wire

### src/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Bounded double-ended queue of 32-bit entries held in a ring store.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                           | accepted
//  --------+-----+---------------------------------------------------+----------------
//  cfg     | in  | capacity[10:0]                                    | valid && ready
//  req     | in  | cmd[1:0], push_value[31:0]                        | valid && ready
//  rsp     | out | ok, front_value, back_value, is_empty, is_full    | valid && ready
//
//  Up to one command per cycle while rsp is not stalled.
//  The command cycle updates pointers, writes the store and reads both ends
//  on the store's two read ports into the pending stage; the result is built as it moves to rsp.
//  Reset (rst, synchronous) empties the queue and sets capacity to DEPTH, at most 1024.
//  A capacity write empties the queue. cfg is always ready.
//  A stalled rsp holds the result; one further command waits in a pending stage.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  cdq_cfg_if.sink   cfg,
  cdq_cmd_if.sink   req,
  cdq_res_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          acc;
  logic          in_ready;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  data_t         wr_data;
  logic [AW-1:0] rd_addr_front;
  logic [AW-1:0] rd_addr_back;
  data_t         rd_front;
  data_t         rd_back;
  meta_t         meta;

  assign cfg.ready = 1'b1;
  assign req.ready = in_ready;
  assign acc       = req.valid && in_ready;

  cdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.capacity),
    .acc           (acc),
    .cmd           (req.cmd),
    .push_value    (req.push_value),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr_front (rd_addr_front),
    .rd_addr_back  (rd_addr_back),
    .meta          (meta)
  );

  cdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk           (clk),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (acc),
    .rd_addr_front (rd_addr_front),
    .rd_addr_back  (rd_addr_back),
    .rd_front      (rd_front),
    .rd_back       (rd_back)
  );

  cdq_out u_out (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .meta     (meta),
    .rd_front (rd_front),
    .rd_back  (rd_back),
    .in_ready (in_ready),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

### src/cdq_chk.sv
// ----------------------------------------------------------------------------
// cdq_chk
// Port-level checks on the deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_chk
  import cdq_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  rsp_valid,
  input wire logic  rsp_ready,
  input wire logic  rsp_ok,
  input wire data_t rsp_front,
  input wire data_t rsp_back,
  input wire logic  rsp_empty,
  input wire logic  rsp_full
);

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_front) && $stable(rsp_back)
      && $stable(rsp_ok) && $stable(rsp_empty) && $stable(rsp_full))
    else $error("rsp changed while stalled");

  // Empty queue reports -1 at both ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_empty |-> (rsp_front == -32'sd1) && (rsp_back == -32'sd1))
    else $error("empty queue reported an entry");

  // Capacity is at least one, so never both empty and full
  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_empty && rsp_full))
    else $error("queue reported empty and full");

  // No response straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind circular_deque cdq_chk u_cdq_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_ok    (rsp.ok),
  .rsp_front (rsp.front_value),
  .rsp_back  (rsp.back_value),
  .rsp_empty (rsp.is_empty),
  .rsp_full  (rsp.is_full)
);

`default_nettype wire
